[hdl/shortest_path_distances_unit_assert.svh]
// assertion macros for the shortest path distances unit
`ifndef SHORTEST_PATH_DISTANCES_UNIT_ASSERT_SVH
`define SHORTEST_PATH_DISTANCES_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define SPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spd assertion failed");
// next-cycle implication, off during reset
`define SPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spd assertion failed");
`else
`define SPD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/spd_pkg.sv]
// shared types and constants for the shortest path distances unit
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  localparam int DIST_BITS = 20;
  localparam int CFG_BITS  = 5;

  localparam logic [DIST_BITS-1:0] UNREACHABLE  = 20'd1000000;
  localparam logic [CFG_BITS-1:0]  VCOUNT_RESET = 5'd16;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_RUN   = 1'b1;

  typedef struct packed {
    logic       action;
    logic [3:0] row_vertex;
    logic [3:0] col_vertex;
    logic [7:0] edge_weight;
  } item_t;

  typedef struct packed {
    logic [3:0]           target_vertex;
    logic [DIST_BITS-1:0] path_distance;
    logic                 last_of_run;
  } result_t;

endpackage

`default_nettype wire

[hdl/shortest_path_distances_unit.sv]
// top level of the shortest path distances unit (single-source dijkstra)
// edge write: accepted in idle, mirror entry stored the next cycle, then ready again
// run with n vertices in use: seed n distances, then at most n relax passes through the
// shared add/compare unit, then one distance transfer per vertex (each may stall on the
// output); one item at a time
// after reset a clearing pass zeroes all MAX_VERTICES * MAX_VERTICES edge memory entries
`timescale 1ns / 1ps
`default_nettype none
`include "shortest_path_distances_unit_assert.svh"

module shortest_path_distances_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          item_valid,
  output      logic                          item_ready,
  input  wire spd_pkg::item_t                item,
  // distance channel
  output      logic                          result_valid,
  input  wire logic                          result_ready,
  output      spd_pkg::result_t              result,
  // vertex count register
  input  wire logic                          cfg_wr_en,
  input  wire logic [spd_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  // vertex index, count and compare widths
  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int CNTW   = $clog2(MAX_VERTICES + 1);
  localparam int CMPW   = (CNTW > spd_pkg::CFG_BITS) ? CNTW : spd_pkg::CFG_BITS;
  // edge memory geometry
  localparam int EDEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int EAW    = $clog2(EDEPTH);
  // distance and widened sum
  localparam int DW     = spd_pkg::DIST_BITS;
  localparam int SW     = DW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MIRROR,
    ST_INIT,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_HOLD
  } state_t;

  state_t state;

  // configuration
  logic [spd_pkg::CFG_BITS-1:0] vertex_count;
  logic [CNTW-1:0]              n_use;
  logic [CMPW-1:0]              vc_ext;

  // request decode
  logic [CMPW-1:0]        row_ext;
  logic [CMPW-1:0]        col_ext;
  logic [VW-1:0]          row_idx;
  logic [VW-1:0]          col_idx;
  logic [15:0]            weight_ext;
  logic [WEIGHT_BITS-1:0] weight_in;
  logic                   wr_in_range;
  logic                   item_xfer;

  // pending mirror write
  logic [VW-1:0]          wr_row;
  logic [VW-1:0]          wr_col;
  logic [WEIGHT_BITS-1:0] wr_weight;

  // edge memory (one write, one registered read)
  logic [WEIGHT_BITS-1:0] edge_mem [0:EDEPTH-1];
  logic                   edge_we;
  logic [EAW-1:0]         edge_waddr;
  logic [WEIGHT_BITS-1:0] edge_wdata;
  logic                   edge_re;
  logic [EAW-1:0]         edge_raddr;
  logic [WEIGHT_BITS-1:0] edge_rd;
  logic [EAW-1:0]         clr_addr;

  // tentative distance memory
  logic [DW-1:0]          dist_mem [0:MAX_VERTICES-1];
  logic                   dist_we;
  logic [VW-1:0]          dist_waddr;
  logic [DW-1:0]          dist_wdata;
  logic                   dist_re;
  logic [VW-1:0]          dist_raddr;
  logic [DW-1:0]          dist_rd;

  // run sequencer state
  logic [VW-1:0]           src;
  logic                    src_ok;
  logic [CNTW-1:0]         cnt;
  logic [MAX_VERTICES-1:0] settled;
  logic [VW-1:0]           cur;
  logic [DW-1:0]           cur_dist;
  logic [CNTW-1:0]         rd_cnt;
  logic                    p_vld;
  logic [VW-1:0]           p_idx;
  logic                    found;
  logic [VW-1:0]           best_idx;
  logic [DW-1:0]           best_dist;

  // shared relax unit
  logic [SW-1:0]           sum;
  logic [DW-1:0]           sum_sat;
  logic                    improve;
  logic [DW-1:0]           new_dist;
  logic                    candidate;

  // output registers
  logic [3:0]              out_vertex;
  logic                    out_last;
  logic [CMPW-1:0]         cnt_ext;

  function automatic logic [EAW-1:0] edge_addr(input logic [VW-1:0] r,
                                                input logic [VW-1:0] c);
    edge_addr = EAW'(r) * EAW'(MAX_VERTICES) + EAW'(c);
  endfunction

  // vertices in use: zero reads as one, anything above the limit as the limit
  assign vc_ext = CMPW'(vertex_count);
  always_comb begin
    if (vc_ext == '0) begin
      n_use = CNTW'(1);
    end else if (vc_ext > CMPW'(MAX_VERTICES)) begin
      n_use = CNTW'(MAX_VERTICES);
    end else begin
      n_use = vc_ext[CNTW-1:0];
    end
  end

  assign row_ext     = CMPW'(item.row_vertex);
  assign col_ext     = CMPW'(item.col_vertex);
  assign row_idx     = row_ext[VW-1:0];
  assign col_idx     = col_ext[VW-1:0];
  assign weight_ext  = 16'(item.edge_weight);
  assign weight_in   = weight_ext[WEIGHT_BITS-1:0];
  // endpoints outside the matrix drop the write
  assign wr_in_range = (row_ext < CMPW'(MAX_VERTICES)) && (col_ext < CMPW'(MAX_VERTICES));

  assign item_ready  = (state == ST_IDLE);
  assign item_xfer   = item_valid && item_ready;

  // relax the settled vertex's neighbour on the distance just read back;
  // the sum saturates at the unreachable mark
  assign sum       = SW'(cur_dist) + SW'(edge_rd);
  assign sum_sat   = (sum > SW'(spd_pkg::UNREACHABLE)) ? spd_pkg::UNREACHABLE : sum[DW-1:0];
  assign improve   = (edge_rd != '0) && (sum_sat < dist_rd);
  assign new_dist  = improve ? sum_sat : dist_rd;
  // running minimum over unsettled vertices, lowest index wins a tie
  assign candidate = p_vld && !settled[p_idx] && (!found || (new_dist < best_dist));

  // memory port steering
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = '0;
    edge_wdata = '0;
    edge_re    = 1'b0;
    edge_raddr = '0;
    dist_we    = 1'b0;
    dist_waddr = '0;
    dist_wdata = '0;
    dist_re    = 1'b0;
    dist_raddr = '0;
    case (state)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_addr;
      end
      ST_IDLE: begin
        // first direction of an edge goes in on the transfer itself
        if (item_xfer && (item.action == spd_pkg::ACT_WRITE) && wr_in_range) begin
          edge_we    = 1'b1;
          edge_waddr = edge_addr(row_idx, col_idx);
          edge_wdata = weight_in;
        end
      end
      ST_WR_MIRROR: begin
        edge_we    = 1'b1;
        edge_waddr = edge_addr(wr_col, wr_row);
        edge_wdata = wr_weight;
      end
      ST_INIT: begin
        // seed: source at zero, everything else unreachable
        dist_we    = 1'b1;
        dist_waddr = cnt[VW-1:0];
        dist_wdata = (src_ok && (cnt[VW-1:0] == src)) ? '0 : spd_pkg::UNREACHABLE;
      end
      ST_RELAX: begin
        if (rd_cnt < n_use) begin
          edge_re    = 1'b1;
          edge_raddr = edge_addr(cur, rd_cnt[VW-1:0]);
          dist_re    = 1'b1;
          dist_raddr = rd_cnt[VW-1:0];
        end
        if (p_vld && improve) begin
          dist_we    = 1'b1;
          dist_waddr = p_idx;
          dist_wdata = sum_sat;
        end
      end
      ST_OUT_RD: begin
        dist_re    = 1'b1;
        dist_raddr = cnt[VW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rd <= edge_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_re) begin
      dist_rd <= dist_mem[dist_raddr];
    end
  end

  assign cnt_ext = CMPW'(cnt);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      vertex_count <= spd_pkg::VCOUNT_RESET;
      result_valid <= 1'b0;
      settled      <= '0;
      cnt          <= '0;
      rd_cnt       <= '0;
      p_vld        <= 1'b0;
      found        <= 1'b0;
      src_ok       <= 1'b0;
      out_last     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      case (state)
        ST_CLEAR: begin
          // zero one edge entry a cycle
          clr_addr <= clr_addr + EAW'(1);
          if (clr_addr == EAW'(EDEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            if (item.action == spd_pkg::ACT_WRITE) begin
              if (wr_in_range) begin
                wr_row    <= row_idx;
                wr_col    <= col_idx;
                wr_weight <= weight_in;
                state     <= ST_WR_MIRROR;
              end
            end else begin
              src     <= row_idx;
              src_ok  <= row_ext < CMPW'(n_use);
              settled <= '0;
              cnt     <= '0;
              state   <= ST_INIT;
            end
          end
        end
        ST_WR_MIRROR: begin
          state <= ST_IDLE;
        end
        ST_INIT: begin
          cnt <= cnt + CNTW'(1);
          if ((cnt + CNTW'(1)) == n_use) begin
            cnt <= '0;
            if (src_ok) begin
              // the source is the first vertex to settle
              cur           <= src;
              cur_dist      <= '0;
              settled[src]  <= 1'b1;
              rd_cnt        <= '0;
              p_vld         <= 1'b0;
              found         <= 1'b0;
              state         <= ST_RELAX;
            end else begin
              state <= ST_OUT_RD;
            end
          end
        end
        ST_RELAX: begin
          if (rd_cnt < n_use) begin
            rd_cnt <= rd_cnt + CNTW'(1);
            p_vld  <= 1'b1;
            p_idx  <= rd_cnt[VW-1:0];
          end else begin
            p_vld <= 1'b0;
          end
          if (candidate) begin
            found     <= 1'b1;
            best_idx  <= p_idx;
            best_dist <= new_dist;
          end
          if ((rd_cnt == n_use) && !p_vld) begin
            // pass done: settle the minimum, or stop once nothing reachable is left
            if (found && (best_dist < spd_pkg::UNREACHABLE)) begin
              cur               <= best_idx;
              cur_dist          <= best_dist;
              settled[best_idx] <= 1'b1;
              rd_cnt            <= '0;
              found             <= 1'b0;
            end else begin
              cnt   <= '0;
              state <= ST_OUT_RD;
            end
          end
        end
        ST_OUT_RD: begin
          result_valid <= 1'b1;
          out_vertex   <= cnt_ext[3:0];
          out_last     <= (cnt + CNTW'(1)) == n_use;
          state        <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              cnt   <= cnt + CNTW'(1);
              state <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // distance read register holds steady while a transfer waits
  assign result.target_vertex = out_vertex;
  assign result.path_distance = dist_rd;
  assign result.last_of_run   = out_last;

  // no request taken while a distance is on offer
  `SPD_ASSERT_IMPL(a_ready_excl_result, clk, rst, result_valid, !item_ready)
  // stored distances never pass the unreachable mark
  `SPD_ASSERT_IMPL(a_dist_bounded, clk, rst, dist_we, dist_wdata <= spd_pkg::UNREACHABLE)
  // a relax write always shortens the entry
  `SPD_ASSERT_IMPL(a_relax_shortens, clk, rst, (state == ST_RELAX) && dist_we, dist_wdata < dist_rd)
  // each distance transfer is followed by a read cycle before the next is offered
  `SPD_ASSERT_NEXT(a_result_gap, clk, rst, result_valid && result_ready && !out_last, !result_valid)

endmodule

`default_nettype wire
